// ===== rtl/segment_index_box_parser_macros.svh =====
// Assertion helpers, clocked on aclk and held off during reset.
`ifndef SEGMENT_INDEX_BOX_PARSER_MACROS_SVH
`define SEGMENT_INDEX_BOX_PARSER_MACROS_SVH

// Consequent checked in the same cycle.
`define SIPB_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define SIPB_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/sipb_pkg.sv =====
package sipb_pkg;

    localparam logic [31:0] SIDX_TYPE   = 32'h73696478;
    localparam logic [31:0] TICKS_RESET = 32'd1000000000;

    localparam int DIV_STEPS = 96;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    localparam logic [2:0] KIND_ENTRY      = 3'd0;
    localparam logic [2:0] KIND_DONE_EMPTY = 3'd1;
    localparam logic [2:0] KIND_BAD_TYPE   = 3'd2;
    localparam logic [2:0] KIND_ZERO_SIZE  = 3'd3;
    localparam logic [2:0] KIND_ZERO_TS    = 3'd4;

    // controller to datapath
    typedef struct packed {
        logic accept;
        logic mul_lo;
        logic mul_hi;
        logic add;
        logic div_step;
        logic scale_wb;
        logic emit;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic evt_res;   // accepted word causes a result without division
        logic evt_div;   // accepted word needs a rescale division
        logic op_entry;  // pending division belongs to an entry
        logic out_free;  // output register can take a result
    } stat_t;

endpackage

// ===== rtl/sipb_ctrl.sv =====
`include "segment_index_box_parser_macros.svh"

module sipb_ctrl (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_tvalid,
    output logic            s_tready,
    input  sipb_pkg::stat_t stat,
    output sipb_pkg::cmd_t  cmd
);

    localparam logic [2:0] ST_RUN    = 3'd0;
    localparam logic [2:0] ST_MUL_LO = 3'd1;
    localparam logic [2:0] ST_MUL_HI = 3'd2;
    localparam logic [2:0] ST_ADD    = 3'd3;
    localparam logic [2:0] ST_DIV    = 3'd4;
    localparam logic [2:0] ST_WB     = 3'd5;
    localparam logic [2:0] ST_EMIT   = 3'd6;

    localparam logic [sipb_pkg::DIV_CNT_W-1:0] CNT_LAST =
        sipb_pkg::DIV_CNT_W'(sipb_pkg::DIV_STEPS - 1);

    logic [2:0] state_reg, state_next;
    logic [sipb_pkg::DIV_CNT_W-1:0] cnt_reg, cnt_next;

    assign s_tready = (state_reg == ST_RUN);

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        case (state_reg)
            ST_RUN: begin
                cmd.accept = s_tvalid;
                if (s_tvalid) begin
                    if (stat.evt_div) begin
                        state_next = ST_MUL_LO;
                    end else if (stat.evt_res) begin
                        state_next = ST_EMIT;
                    end
                end
            end
            ST_MUL_LO: begin
                cmd.mul_lo = 1'b1;
                state_next = ST_MUL_HI;
            end
            ST_MUL_HI: begin
                cmd.mul_hi = 1'b1;
                state_next = ST_ADD;
            end
            ST_ADD: begin
                cmd.add    = 1'b1;
                cnt_next   = '0;
                state_next = ST_DIV;
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == CNT_LAST) begin
                    state_next = ST_WB;
                end
            end
            ST_WB: begin
                cmd.scale_wb = !stat.op_entry;
                state_next   = stat.op_entry ? ST_EMIT : ST_RUN;
            end
            ST_EMIT: begin
                if (stat.out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = ST_RUN;
                end
            end
            default: begin
                state_next = ST_RUN;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_RUN;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    `SIPB_ASSERT_NEXT(a_div_starts, cmd.accept && stat.evt_div, state_reg == ST_MUL_LO, "division did not start")
    `SIPB_ASSERT_NEXT(a_div_ends, state_reg == ST_DIV && cnt_reg == CNT_LAST, state_reg == ST_WB, "division overran")
    `SIPB_ASSERT_NEXT(a_emit_returns, cmd.emit, state_reg == ST_RUN, "emit did not return to run")

endmodule

// ===== rtl/sipb_dp.sv =====
`include "segment_index_box_parser_macros.svh"

module sipb_dp (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            cfg_valid,
    input  logic [31:0]     cfg_data,
    input  logic [7:0]      in_byte,
    input  logic            in_start,
    input  sipb_pkg::cmd_t  cmd,
    output sipb_pkg::stat_t stat,
    input  logic            m_tready,
    output logic            m_tvalid,
    output logic [335:0]    m_tdata,
    output logic [2:0]      m_tuser,
    output logic            m_tlast
);

    localparam logic [2:0] PH_HEAD  = 3'd0;
    localparam logic [2:0] PH_LARGE = 3'd1;
    localparam logic [2:0] PH_FULL  = 3'd2;
    localparam logic [2:0] PH_ENTRY = 3'd3;
    localparam logic [2:0] PH_DONE  = 3'd4;

    logic [31:0] ticks_reg;

    logic [2:0]  phase_reg, phase_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic [63:0] shift_reg, shift_next;
    logic [63:0] size_reg, size_next;
    logic        ver_reg, ver_next;
    logic [31:0] ts_reg, ts_next;
    logic [63:0] fo_reg, fo_next;
    logic [15:0] total_reg, total_next;
    logic [15:0] idx_reg, idx_next;
    logic [63:0] ssum_reg, ssum_next;
    logic [63:0] tsum_reg, tsum_next;
    logic [31:0] w0_reg, w0_next;
    logic [31:0] w1_reg, w1_next;
    logic [31:0] w2_reg, w2_next;
    logic        op_entry_reg, op_entry_next;
    logic [2:0]  kind_reg, kind_next;
    logic        evt_res, evt_div;

    logic [63:0] prod_lo_reg, prod_hi_reg;
    logic [95:0] dvd_reg;
    logic [31:0] rem_reg;
    logic [63:0] mul_src;
    logic [32:0] rem_sh, rem_sub;
    logic        rem_ge;
    logic        entry_last;

    logic        out_valid_reg;
    logic [335:0] out_data_reg;
    logic [2:0]  out_kind_reg;
    logic        out_last_reg;

    // byte parser: mirrors the box layout field by field
    always_comb begin
        logic [4:0]  n;
        logic [4:0]  w;
        logic [63:0] fs;
        phase_next    = phase_reg;
        size_next     = size_reg;
        ver_next      = ver_reg;
        ts_next       = ts_reg;
        fo_next       = fo_reg;
        total_next    = total_reg;
        idx_next      = idx_reg;
        ssum_next     = ssum_reg;
        tsum_next     = tsum_reg;
        w0_next       = w0_reg;
        w1_next       = w1_reg;
        w2_next       = w2_reg;
        n             = cnt_reg;
        fs            = shift_reg;
        op_entry_next = op_entry_reg;
        kind_next     = kind_reg;
        evt_res       = 1'b0;
        evt_div       = 1'b0;
        if (in_start) begin
            phase_next = PH_HEAD;
            n          = '0;
            fs         = '0;
            size_next  = '0;
            ver_next   = 1'b0;
            ts_next    = '0;
            fo_next    = '0;
            total_next = '0;
            idx_next   = '0;
            ssum_next  = '0;
            tsum_next  = '0;
            w0_next    = '0;
            w1_next    = '0;
            w2_next    = '0;
        end
        shift_next = {fs[55:0], in_byte};
        cnt_next   = n + 5'd1;
        w          = ver_next ? 5'd4 : 5'd0;
        case (phase_next)
            PH_HEAD: begin
                if (n == 5'd3) begin
                    size_next = {32'd0, shift_next[31:0]};
                end else if (n == 5'd7) begin
                    cnt_next = '0;
                    if (shift_next[31:0] != sipb_pkg::SIDX_TYPE) begin
                        phase_next = PH_DONE;
                        evt_res    = 1'b1;
                        kind_next  = sipb_pkg::KIND_BAD_TYPE;
                    end else if (size_next == 64'd1) begin
                        phase_next = PH_LARGE;
                    end else if (size_next == 64'd0) begin
                        phase_next = PH_DONE;
                        evt_res    = 1'b1;
                        kind_next  = sipb_pkg::KIND_ZERO_SIZE;
                    end else begin
                        phase_next = PH_FULL;
                    end
                end
            end
            PH_LARGE: begin
                if (n == 5'd7) begin
                    cnt_next  = '0;
                    size_next = shift_next;
                    if (shift_next == 64'd0) begin
                        phase_next = PH_DONE;
                        evt_res    = 1'b1;
                        kind_next  = sipb_pkg::KIND_ZERO_SIZE;
                    end else begin
                        phase_next = PH_FULL;
                    end
                end
            end
            PH_FULL: begin
                if (n == 5'd0) begin
                    ver_next = (in_byte != 8'd0);
                end else if (n == 5'd11) begin
                    ts_next = shift_next[31:0];
                end else if (n == 5'd15 + w) begin
                    tsum_next = ver_next ? shift_next : {32'd0, shift_next[31:0]};
                end else if (n == 5'd19 + (w << 1)) begin
                    fo_next = ver_next ? shift_next : {32'd0, shift_next[31:0]};
                end else if (n == 5'd23 + (w << 1)) begin
                    total_next = shift_next[15:0];
                    idx_next   = '0;
                    ssum_next  = '0;
                    cnt_next   = '0;
                    if (ts_next == 32'd0) begin
                        phase_next = PH_DONE;
                        evt_res    = 1'b1;
                        kind_next  = sipb_pkg::KIND_ZERO_TS;
                    end else if (shift_next[15:0] == 16'd0) begin
                        phase_next = PH_DONE;
                        evt_res    = 1'b1;
                        kind_next  = sipb_pkg::KIND_DONE_EMPTY;
                    end else begin
                        phase_next    = PH_ENTRY;
                        evt_div       = 1'b1;
                        op_entry_next = 1'b0;
                    end
                end
            end
            PH_ENTRY: begin
                if (n > 5'd11) begin
                    cnt_next = '0;
                end else begin
                    if (n == 5'd3) begin
                        w0_next = shift_next[31:0];
                    end
                    if (n == 5'd7) begin
                        w1_next = shift_next[31:0];
                    end
                    if (n == 5'd11) begin
                        w2_next       = shift_next[31:0];
                        cnt_next      = '0;
                        evt_div       = 1'b1;
                        op_entry_next = 1'b1;
                    end
                end
            end
            default: begin
                cnt_next = '0;
            end
        endcase
        // a status result never carries entry fields
        if (evt_res) begin
            op_entry_next = 1'b0;
        end
    end

    assign mul_src    = op_entry_reg ? {32'd0, w1_reg} : tsum_reg;
    assign rem_sh     = {rem_reg, dvd_reg[95]};
    assign rem_ge     = (rem_sh >= {1'b0, ts_reg});
    assign rem_sub    = rem_sh - {1'b0, ts_reg};
    assign entry_last = ({1'b0, idx_reg} + 17'd1 >= {1'b0, total_reg});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ticks_reg    <= sipb_pkg::TICKS_RESET;
            phase_reg    <= PH_HEAD;
            cnt_reg      <= '0;
            shift_reg    <= '0;
            size_reg     <= '0;
            ver_reg      <= 1'b0;
            ts_reg       <= '0;
            fo_reg       <= '0;
            total_reg    <= '0;
            idx_reg      <= '0;
            ssum_reg     <= '0;
            tsum_reg     <= '0;
            w0_reg       <= '0;
            w1_reg       <= '0;
            w2_reg       <= '0;
            op_entry_reg <= 1'b0;
            kind_reg     <= sipb_pkg::KIND_ENTRY;
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_valid) begin
                ticks_reg <= cfg_data;
            end
            if (cmd.accept) begin
                phase_reg    <= phase_next;
                cnt_reg      <= cnt_next;
                shift_reg    <= shift_next;
                size_reg     <= size_next;
                ver_reg      <= ver_next;
                ts_reg       <= ts_next;
                fo_reg       <= fo_next;
                total_reg    <= total_next;
                idx_reg      <= idx_next;
                ssum_reg     <= ssum_next;
                tsum_reg     <= tsum_next;
                w0_reg       <= w0_next;
                w1_reg       <= w1_next;
                w2_reg       <= w2_next;
                op_entry_reg <= op_entry_next;
                kind_reg     <= kind_next;
            end
            // saturate a rescaled earliest time that overflows 64 bits
            if (cmd.scale_wb) begin
                tsum_reg <= (|dvd_reg[95:64]) ? '1 : dvd_reg[63:0];
            end
            if (cmd.emit && op_entry_reg) begin
                ssum_reg <= ssum_reg + {33'd0, w0_reg[30:0]};
                tsum_reg <= tsum_reg + dvd_reg[63:0];
                idx_reg  <= idx_reg + 16'd1;
                if (entry_last) begin
                    phase_reg <= PH_DONE;
                end
            end
            if (cmd.emit) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // multiply, round and divide; no reset on the arithmetic path
    always_ff @(posedge aclk) begin
        if (cmd.mul_lo) begin
            prod_lo_reg <= mul_src[31:0] * ticks_reg;
        end
        if (cmd.mul_hi) begin
            prod_hi_reg <= mul_src[63:32] * ticks_reg;
        end
        if (cmd.add) begin
            dvd_reg <= {prod_hi_reg, 32'd0} + {32'd0, prod_lo_reg} + {65'd0, ts_reg[31:1]};
            rem_reg <= '0;
        end else if (cmd.div_step) begin
            dvd_reg <= {dvd_reg[94:0], rem_ge};
            rem_reg <= rem_ge ? rem_sub[31:0] : rem_sh[31:0];
        end
        if (cmd.emit) begin
            out_last_reg <= op_entry_reg ? entry_last : 1'b1;
            out_kind_reg <= op_entry_reg ? sipb_pkg::KIND_ENTRY : kind_reg;
            if (op_entry_reg) begin
                out_data_reg <= {fo_reg, idx_reg, w2_reg[27:0], w2_reg[30:28],
                                 w2_reg[31], w0_reg[30:0], w0_reg[31], dvd_reg[63:0],
                                 tsum_reg, ssum_reg};
            end else begin
                out_data_reg <= {(kind_reg == sipb_pkg::KIND_ZERO_TS ||
                                  kind_reg == sipb_pkg::KIND_DONE_EMPTY) ? fo_reg : 64'd0,
                                 272'd0};
            end
        end
    end

    assign stat.evt_res  = evt_res;
    assign stat.evt_div  = evt_div;
    assign stat.op_entry = op_entry_reg;
    assign stat.out_free = !out_valid_reg || m_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_kind_reg;
    assign m_tlast  = out_last_reg;

    `SIPB_ASSERT_NOW(a_emit_free, cmd.emit, !out_valid_reg || m_tready, "result overwrote a waiting word")
    `SIPB_ASSERT_NOW(a_div_nonzero, cmd.div_step, ts_reg != 32'd0, "division by zero timescale")
    `SIPB_ASSERT_NOW(a_status_last, m_tvalid && out_kind_reg != sipb_pkg::KIND_ENTRY, m_tlast, "status result not last")

endmodule

// ===== rtl/segment_index_box_parser.sv =====
// channel   dir  handshake            payload
// s_        in   s_tvalid/s_tready    s_tdata: data_byte; s_tuser: box_start
// m_        out  m_tvalid/m_tready    m_tdata: entry fields; m_tuser: kind; m_tlast: last
// cfg_      in   cfg_valid/cfg_ready  cfg_data: output_ticks_per_second
//
// Header and entry bytes are taken one per cycle while s_tready is high.
// The entry count byte holds s_tready low for two 32x32 multiplies,
// one add, a 96-step restoring divider and write-back; an entry's last byte
// holds it low for the same steps plus any wait for the output register.
// A status result holds s_tready low for its emit step plus any wait on m_tready.
// Reset is synchronous, active low; cfg_ready is always high.
module segment_index_box_parser (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,   // data_byte
    input  logic         s_tuser,   // box_start
    output logic         m_tvalid,
    input  logic         m_tready,
    // entry_offset, entry_time, entry_duration, reference_type,
    // referenced_size, sap_start, sap_kind, sap_delta, entry_number,
    // base_offset
    output logic [335:0] m_tdata,
    output logic [2:0]   m_tuser,   // result_kind
    output logic         m_tlast,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [31:0]  cfg_data
);

    sipb_pkg::cmd_t  cmd;
    sipb_pkg::stat_t stat;

    assign cfg_ready = 1'b1;

    sipb_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    sipb_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .in_byte   (s_tdata),
        .in_start  (s_tuser),
        .cmd       (cmd),
        .stat      (stat),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule
